// ===== sv/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants of the table search engine
// Field structs, method codes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int SizeW      = IdxW + 1;
  localparam int CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CfgTableSize    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSearchMethod = 1'b1;

  localparam logic [1:0] MethLinear   = 2'd0;
  localparam logic [1:0] MethSentinel = 2'd1;
  localparam logic [1:0] MethBinary   = 2'd2;
  localparam logic [1:0] MethJump     = 2'd3;

  localparam logic FuncWrite  = 1'b0;
  localparam logic FuncSearch = 1'b1;

  typedef struct packed {
    logic               func;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_data;
    logic signed [31:0] entry_key;
    logic signed [31:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] record_key;
    logic [9:0]         match_index;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eq;
    logic gt;
  } dp_sts_t;

endpackage

// ===== sv/tse_datapath.sv =====
// ----------------------------------------------------------------------------
// tse_datapath: record memories and probe compare
// One write port, one registered read port; compares a probe with the key.
// ----------------------------------------------------------------------------
module tse_datapath (
  input  logic                    clk,
  input  tse_pkg::dp_cmd_t        cmd,
  input  logic signed [31:0]      wr_data,
  input  logic signed [31:0]      wr_key,
  input  logic signed [31:0]      key,
  output tse_pkg::dp_sts_t        sts,
  output logic signed [31:0]      rd_key
);
  import tse_pkg::*;

  logic [31:0] data_mem [TableDepth];
  logic [31:0] key_mem  [TableDepth];
  logic signed [31:0] rd_data_r;
  logic signed [31:0] rd_key_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      data_mem[cmd.wr_addr] <= wr_data;
      key_mem[cmd.wr_addr]  <= wr_key;
    end
    if (cmd.rd_en) begin
      rd_data_r <= data_mem[cmd.rd_addr];
      rd_key_r  <= key_mem[cmd.rd_addr];
    end
  end

  assign sts.eq = (rd_data_r == key);
  assign sts.gt = (rd_data_r > key);
  assign rd_key = rd_key_r;

endmodule

// ===== sv/tse_ctrl.sv =====
// ----------------------------------------------------------------------------
// tse_ctrl: search sequencer
// Issues probe addresses for linear, binary and jump searches and decides.
// ----------------------------------------------------------------------------
module tse_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tse_pkg::SizeW-1:0] n,
  input  logic [1:0]               method,
  input  tse_pkg::dp_sts_t         sts,
  input  logic                     res_hold,
  output tse_pkg::dp_cmd_t         cmd_rd,
  output logic                     busy,
  output logic                     done,
  output logic                     hit,
  output logic [tse_pkg::IdxW-1:0] hit_idx
);
  import tse_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SQRT  = 6'b000010,
    S_PROBE = 6'b000100,
    S_WAIT  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Kinds of probe under way.
  localparam logic [1:0] PkLin  = 2'd0;
  localparam logic [1:0] PkBin  = 2'd1;
  localparam logic [1:0] PkJblk = 2'd2;
  localparam logic [1:0] PkJscn = 2'd3;

  state_t state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  // Signed working values, wide enough for n, -1 and sums.
  logic signed [SizeW+1:0] lo_r, lo_nxt, hi_r, hi_nxt;   // bin lo/hi; jump j / scan end
  logic signed [SizeW+1:0] off_r, off_nxt, i_r, i_nxt;
  logic [SizeW-1:0] s_r, s_nxt;
  logic [IdxW-1:0]  addr_r, addr_nxt;
  logic             hit_r, hit_nxt;
  logic [IdxW-1:0]  hidx_r, hidx_nxt;
  logic signed [SizeW+1:0] nn, mid, jo, jn;
  logic [2*SizeW+1:0] sq;

  assign nn  = signed'({2'b00, n});
  assign mid = (lo_r + hi_r) >>> 1;
  assign jo  = lo_r + off_r;
  assign sq  = ({1'b0, s_r} + 1'b1) * ({1'b0, s_r} + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
    end
    kind_r <= kind_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; off_r <= off_nxt;
    i_r <= i_nxt; s_r <= s_nxt; addr_r <= addr_nxt; hidx_r <= hidx_nxt;
  end

  always_comb begin
    state_nxt = state_r; kind_nxt = kind_r; lo_nxt = lo_r; hi_nxt = hi_r;
    off_nxt = off_r; i_nxt = i_r; s_nxt = s_r; addr_nxt = addr_r;
    hit_nxt = hit_r; hidx_nxt = hidx_r;
    jn = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          hit_nxt = 1'b0; hidx_nxt = '0;
          lo_nxt = '0; hi_nxt = nn - 1; i_nxt = '0; s_nxt = '0;
          case (method)
            MethBinary: begin kind_nxt = PkBin;  state_nxt = S_PROBE; end
            MethJump:   begin kind_nxt = PkJblk; state_nxt = S_SQRT;  end
            default:    begin kind_nxt = PkLin;  state_nxt = S_PROBE; end
          endcase
        end
      end
      S_SQRT: begin
        // Integer square root by counting up, one step a cycle.
        if (sq <= {{(SizeW+2){1'b0}}, n}) s_nxt = s_r + 1'b1;
        else begin
          off_nxt = signed'({2'b00, s_r}) - 1;
          lo_nxt  = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = S_WAIT;
        case (kind_r)
          PkLin: begin
            if (i_r >= nn) state_nxt = S_DONE;
            else addr_nxt = i_r[IdxW-1:0];
          end
          PkBin: begin
            if (lo_r > hi_r) state_nxt = S_DONE;
            else addr_nxt = mid[IdxW-1:0];
          end
          PkJscn: begin
            if (i_r >= hi_r) state_nxt = S_DONE;
            else addr_nxt = i_r[IdxW-1:0];
          end
          default: begin
            if (lo_r >= nn) state_nxt = S_DONE;
            else if (jo < nn && off_r >= 0) addr_nxt = jo[IdxW-1:0];
            else begin
              // Skip to next block without a probe.
              jn = jo + 1;
              lo_nxt = jn;
              if (jn + off_r >= nn) off_nxt = nn - jn - 1;
              state_nxt = S_PROBE;
            end
          end
        endcase
      end
      S_WAIT: state_nxt = S_CHECK;
      S_CHECK: begin
        state_nxt = S_PROBE;
        if (sts.eq) begin
          hit_nxt = 1'b1; hidx_nxt = addr_r; state_nxt = S_DONE;
        end else begin
          case (kind_r)
            PkLin, PkJscn: i_nxt = i_r + 1;
            PkBin: begin
              if (sts.gt) hi_nxt = mid - 1;
              else lo_nxt = mid + 1;
            end
            default: begin
              if (sts.gt) begin
                kind_nxt = PkJscn; i_nxt = lo_r; hi_nxt = jo;
              end else begin
                jn = jo + 1;
                lo_nxt = jn;
                if (jn + off_r >= nn) off_nxt = nn - jn - 1;
              end
            end
          endcase
        end
      end
      // The finished result waits here while the output register is full.
      S_DONE: begin
        if (!res_hold) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cmd_rd.wr_en   = 1'b0;
  assign cmd_rd.wr_addr = '0;
  assign cmd_rd.rd_en   = (state_r == S_WAIT);
  assign cmd_rd.rd_addr = addr_r;
  assign busy    = (state_r != S_IDLE);
  assign done    = (state_r == S_DONE) && !res_hold;
  assign hit     = hit_r;
  assign hit_idx = hidx_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == S_IDLE) else $error("done not followed by idle");
  a_hit_lt_n: assert property (@(posedge clk) disable iff (!rst_n)
    (done && hit) |-> {1'b0, hit_idx} < n) else $error("hit beyond size");

endmodule

// ===== sv/table_search_engine_unit.sv =====
// ----------------------------------------------------------------------------
// table_search_engine_unit: record table with linear, binary and jump search
// Write items load records; search items return one result beat.
// ----------------------------------------------------------------------------
//  channel  | ports                         | role
//  in_      | in_valid/in_ready/in_data     | write or search item beat
//  out_     | out_valid/out_ready/out_data  | search result beat
//  cfg_     | cfg_valid/cfg_ready/cfg_index | register write (size, method)
//
// A write item is stored when accepted. Each search probe passes through issue,
// registered memory read and compare; a linear scan makes up to n probes, a
// binary search up to floor(log2(n))+1, and a jump search first counts up the
// integer square root of n, then probes blocks and scans, skipping a block
// without a probe when its last entry lies beyond the table.
// Reset is synchronous and active low; the memories are not cleared. A
// waiting result is held in the output register while the next item is
// accepted; a search that finishes before it is taken waits in the
// controller's done state and holds off further items.
module table_search_engine_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tse_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tse_pkg::out_item_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import tse_pkg::*;

  logic [SizeW-1:0] size_r, n;
  logic [1:0]       method_r;
  logic signed [31:0] key_r;
  dp_cmd_t cmd, cmd_rd;
  dp_sts_t sts;
  logic busy, done, hit;
  logic [IdxW-1:0] hit_idx;
  logic signed [31:0] rd_key;
  logic in_acc, start;
  logic res_hold;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0; method_r <= MethLinear;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgTableSize:    size_r   <= cfg_data[SizeW-1:0];
        CfgSearchMethod: method_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end
  // Oversized sizes saturate at the table depth.
  assign n = (size_r > SizeW'(TableDepth)) ? SizeW'(TableDepth) : size_r;

  // A new item is taken whenever the engine is idle. The output register
  // parts the two sides, so a pending result does not block writes.
  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && (in_data.func == FuncSearch);

  // The output register is full and its result is not being taken.
  assign res_hold = out_valid && !out_ready;

  always_ff @(posedge clk) if (start) key_r <= in_data.search_key;

  always_comb begin
    cmd = cmd_rd;
    cmd.wr_en   = in_acc && (in_data.func == FuncWrite);
    cmd.wr_addr = in_data.entry_index[IdxW-1:0];
  end

  tse_datapath u_dp (
    .clk(clk), .cmd(cmd), .wr_data(in_data.entry_data), .wr_key(in_data.entry_key),
    .key(key_r), .sts(sts), .rd_key(rd_key)
  );

  tse_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .n(n), .method(method_r), .sts(sts),
    .res_hold(res_hold), .cmd_rd(cmd_rd), .busy(busy), .done(done), .hit(hit),
    .hit_idx(hit_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (done) begin
      out_data.found       <= hit;
      out_data.record_key  <= hit ? rd_key : '0;
      out_data.match_index <= hit ? hit_idx : '0;
    end
  end

  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("accept while busy");
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid || out_ready)) else $error("result overwrite");
  a_start_res: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy) else $error("search not started");

endmodule
